// ===== rtl/itew_pkg.sv =====
package itew_pkg;

  // word codes
  localparam logic [4:0] WORD_ZERO     = 5'd0;
  localparam logic [4:0] WORD_TEN      = 5'd10;
  localparam logic [4:0] WORD_TWENTY   = 5'd20;
  localparam logic [4:0] WORD_HUNDRED  = 5'd28;
  localparam logic [4:0] WORD_THOUSAND = 5'd29;
  localparam logic [4:0] WORD_MILLION  = 5'd30;
  localparam logic [4:0] WORD_BILLION  = 5'd31;

  localparam int unsigned NumBits   = 31;
  localparam int unsigned NumDigits = 10;
  localparam int unsigned StepW     = 4;

  // condition codes tested by a control word
  typedef enum logic [3:0] {
    C_ALWAYS,
    C_BCD_BUSY,
    C_NUM_ZERO,
    C_GRP_ZERO,
    C_H_NZ,
    C_T_ONE,
    C_T_GE2,
    C_O_NZ,
    C_HAS_SCALE,
    C_LAST_GRP
  } cond_e;

  // word source for an emit step
  typedef enum logic [2:0] {
    E_NONE,
    E_HUND_DIGIT,
    E_HUNDRED,
    E_TEEN,
    E_TENS,
    E_ONES,
    E_SCALE,
    E_ZERO
  } emit_e;

  // jump mode
  typedef enum logic [1:0] {
    J_NONE,
    J_TRUE,
    J_FALSE
  } jmp_e;

  // datapath operation
  typedef enum logic [1:0] {
    OP_NONE,
    OP_LOAD,
    OP_NEXT_GRP,
    OP_FLUSH
  } op_e;

  typedef struct packed {
    cond_e             cond;
    emit_e             emit;
    jmp_e              jmp;
    logic [StepW-1:0]  tgt;
    op_e               op;
  } ctrl_t;

  // status flags fed back to the sequencer
  typedef struct packed {
    logic bcd_busy;
    logic num_zero;
    logic grp_zero;
    logic h_nz;
    logic t_one;
    logic t_ge2;
    logic o_nz;
    logic has_scale;
    logic last_grp;
  } flags_t;

endpackage

// ===== rtl/integer_to_english_word_tokens.sv =====
// Spells out a non-negative integer as a run of English word codes.
// Input channel s_axis: one transaction carries the number in tdata[30:0];
// bit 31 is ignored. Output channel m_axis: one transaction per word,
// word code in tdata[4:0], tlast high on the final word of the number.
// A number gives one to sixteen words; zero gives the single word Zero.
// Operation: a small microcoded sequencer steps through a
// 14-word program. After the input transaction a bit-serial binary to
// decimal converter works through all 31 input bits, then each group of
// three digits takes 3 steps when it is zero and up to 9 steps otherwise,
// with at most one word per step. A new number is accepted only at the
// load step, once the flush step has passed the last word on.
// The last word is known only when the program ends, so one word is held
// back in a pending register and leaves with tlast at the final step.
// When the receiver stalls, the output register holds its word and the
// sequencer waits on any step that needs to pass a word forward.
// Reset returns the sequencer to the load step with nothing pending.
module integer_to_english_word_tokens
  import itew_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [30:0] number
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [4:0] word_code
  output logic        m_axis_tlast_o    // last_word
);

  ctrl_t                  ctrl;
  logic                   cond;
  flags_t                 flags;
  logic                   stall;
  logic                   bcd_busy;
  logic [4*NumDigits-1:0] digits;
  logic                   load;
  logic [1:0]             grp_q;
  logic [3:0]             h, t, o;
  logic [4:0]             word;
  logic                   emit_do;
  logic                   out_stuck;
  logic                   push_out;
  logic                   push_last;
  logic                   pend_vld_q;
  logic [4:0]             pend_code_q;
  logic                   out_vld_q;
  logic [4:0]             out_code_q;
  logic                   out_last_q;

  itew_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .stall_i (stall),
    .ctrl_o  (ctrl),
    .cond_o  (cond)
  );

  assign load = (ctrl.op == OP_LOAD) && s_axis_tvalid_i;

  itew_bcd u_bcd (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (load),
    .bin_i    (s_axis_tdata_i[NumBits-1:0]),
    .busy_o   (bcd_busy),
    .digits_o (digits)
  );

  // digits of the current group
  always_comb begin
    unique case (grp_q)
      2'd0: begin
        h = 4'd0;
        t = 4'd0;
        o = digits[39:36];
      end
      2'd1: begin
        h = digits[35:32];
        t = digits[31:28];
        o = digits[27:24];
      end
      2'd2: begin
        h = digits[23:20];
        t = digits[19:16];
        o = digits[15:12];
      end
      default: begin
        h = digits[11:8];
        t = digits[7:4];
        o = digits[3:0];
      end
    endcase
  end

  // status flags
  always_comb begin
    flags.bcd_busy  = bcd_busy;
    flags.num_zero  = (digits == '0);
    flags.grp_zero  = (h == 4'd0) && (t == 4'd0) && (o == 4'd0);
    flags.h_nz      = (h != 4'd0);
    flags.t_one     = (t == 4'd1);
    flags.t_ge2     = (t >= 4'd2);
    flags.o_nz      = (o != 4'd0);
    flags.has_scale = (grp_q != 2'd3);
    flags.last_grp  = (grp_q == 2'd3);
  end

  // word code for the current emit step
  always_comb begin
    unique case (ctrl.emit)
      E_HUND_DIGIT: word = {1'b0, h};
      E_HUNDRED:    word = WORD_HUNDRED;
      E_TEEN:       word = WORD_TEN + {1'b0, o};
      E_TENS:       word = WORD_TWENTY + {1'b0, t} - 5'd2;
      E_ONES:       word = {1'b0, o};
      E_ZERO:       word = WORD_ZERO;
      E_SCALE: begin
        unique case (grp_q)
          2'd0:    word = WORD_BILLION;
          2'd1:    word = WORD_MILLION;
          default: word = WORD_THOUSAND;
        endcase
      end
      default:      word = WORD_ZERO;
    endcase
  end

  // stall when input is absent or a word cannot move forward
  assign out_stuck = out_vld_q && !m_axis_tready_i;
  assign emit_do   = (ctrl.emit != E_NONE) && cond;
  assign stall     = ((ctrl.op == OP_LOAD) && !s_axis_tvalid_i)
                   || (emit_do && pend_vld_q && out_stuck)
                   || ((ctrl.op == OP_FLUSH) && out_stuck);

  assign push_last = (ctrl.op == OP_FLUSH) && !stall;
  assign push_out  = (emit_do && pend_vld_q && !stall) || push_last;

  // group counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_q <= 2'd0;
    end else if (load) begin
      grp_q <= 2'd0;
    end else if ((ctrl.op == OP_NEXT_GRP) && !stall) begin
      grp_q <= grp_q + 2'd1;
    end
  end

  // pending word and output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (emit_do && !stall) begin
        pend_vld_q <= 1'b1;
      end else if (push_last) begin
        pend_vld_q <= 1'b0;
      end
      if (push_out) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // word payload
  always_ff @(posedge clk_i) begin
    if (emit_do && !stall) begin
      pend_code_q <= word;
    end
    if (push_out) begin
      out_code_q <= pend_code_q;
      out_last_q <= push_last;
    end
  end

  assign s_axis_tready_o = (ctrl.op == OP_LOAD);
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {3'b000, out_code_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule

// ===== rtl/itew_bcd.sv =====
module itew_bcd
  import itew_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [NumBits-1:0]     bin_i,
  output logic                   busy_o,
  output logic [4*NumDigits-1:0] digits_o
);

  logic [NumBits-1:0]     bin_q;
  logic [4*NumDigits-1:0] bcd_q;
  logic [4*NumDigits-1:0] adj;
  logic [4:0]             cnt_q;
  logic                   busy_q;

  // add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  // iteration control, one input bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 5'(NumBits);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_q <= 1'b0;
      end
    end
  end

  // shift registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      bin_q <= bin_i;
      bcd_q <= '0;
    end else if (busy_q) begin
      bin_q <= {bin_q[NumBits-2:0], 1'b0};
      bcd_q <= {adj[4*NumDigits-2:0], bin_q[NumBits-1]};
    end
  end

  assign busy_o   = busy_q;
  assign digits_o = bcd_q;

endmodule

// ===== rtl/itew_seq.sv =====
module itew_seq
  import itew_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  flags_t flags_i,
  input  logic   stall_i,
  output ctrl_t  ctrl_o,
  output logic   cond_o
);

  // program step names
  localparam logic [StepW-1:0] S_LOAD  = 4'd0;
  localparam logic [StepW-1:0] S_WAIT  = 4'd1;
  localparam logic [StepW-1:0] S_GRP   = 4'd3;
  localparam logic [StepW-1:0] S_TENS  = 4'd6;
  localparam logic [StepW-1:0] S_SCALE = 4'd9;
  localparam logic [StepW-1:0] S_NEXT  = 4'd10;
  localparam logic [StepW-1:0] S_ZERO  = 4'd12;
  localparam logic [StepW-1:0] S_FLUSH = 4'd13;

  // microcode table
  function automatic ctrl_t rom(input logic [StepW-1:0] s);
    ctrl_t c;
    c = '{cond: C_ALWAYS, emit: E_NONE, jmp: J_NONE, tgt: S_LOAD, op: OP_NONE};
    unique case (s)
      4'd0:  c.op = OP_LOAD;
      4'd1:  c = '{C_BCD_BUSY, E_NONE, J_TRUE, S_WAIT, OP_NONE};
      4'd2:  c = '{C_NUM_ZERO, E_NONE, J_TRUE, S_ZERO, OP_NONE};
      4'd3:  c = '{C_GRP_ZERO, E_NONE, J_TRUE, S_NEXT, OP_NONE};
      4'd4:  c = '{C_H_NZ, E_HUND_DIGIT, J_FALSE, S_TENS, OP_NONE};
      4'd5:  c = '{C_ALWAYS, E_HUNDRED, J_NONE, S_LOAD, OP_NONE};
      4'd6:  c = '{C_T_ONE, E_TEEN, J_TRUE, S_SCALE, OP_NONE};
      4'd7:  c = '{C_T_GE2, E_TENS, J_NONE, S_LOAD, OP_NONE};
      4'd8:  c = '{C_O_NZ, E_ONES, J_NONE, S_LOAD, OP_NONE};
      4'd9:  c = '{C_HAS_SCALE, E_SCALE, J_NONE, S_LOAD, OP_NONE};
      4'd10: c = '{C_LAST_GRP, E_NONE, J_TRUE, S_FLUSH, OP_NEXT_GRP};
      4'd11: c = '{C_ALWAYS, E_NONE, J_TRUE, S_GRP, OP_NONE};
      4'd12: c = '{C_ALWAYS, E_ZERO, J_NONE, S_LOAD, OP_NONE};
      4'd13: c = '{C_ALWAYS, E_NONE, J_TRUE, S_LOAD, OP_FLUSH};
      default: c.jmp = J_TRUE;
    endcase
    return c;
  endfunction

  logic [StepW-1:0] step_q, step_d;
  ctrl_t            ctrl;
  logic             cond;

  assign ctrl = rom(step_q);

  // condition select
  always_comb begin
    unique case (ctrl.cond)
      C_ALWAYS:    cond = 1'b1;
      C_BCD_BUSY:  cond = flags_i.bcd_busy;
      C_NUM_ZERO:  cond = flags_i.num_zero;
      C_GRP_ZERO:  cond = flags_i.grp_zero;
      C_H_NZ:      cond = flags_i.h_nz;
      C_T_ONE:     cond = flags_i.t_one;
      C_T_GE2:     cond = flags_i.t_ge2;
      C_O_NZ:      cond = flags_i.o_nz;
      C_HAS_SCALE: cond = flags_i.has_scale;
      C_LAST_GRP:  cond = flags_i.last_grp;
      default:     cond = 1'b0;
    endcase
  end

  // next step: hold, jump or advance
  always_comb begin
    step_d = step_q + 4'd1;
    if (stall_i) begin
      step_d = step_q;
    end else begin
      unique case (ctrl.jmp)
        J_TRUE:  if (cond) step_d = ctrl.tgt;
        J_FALSE: if (!cond) step_d = ctrl.tgt;
        default: step_d = step_q + 4'd1;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_LOAD;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o = ctrl;
  assign cond_o = cond;

endmodule

// ===== verif/tb_integer_to_english_word_tokens.sv =====
module tb_integer_to_english_word_tokens;
  import itew_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 120;
  localparam int unsigned MAX_NUMBER = 32'h7FFF_FFFF;

  localparam int unsigned GROUP_DIV [4] = '{1000000000, 1000000, 1000, 1};
  localparam logic [4:0] GROUP_SCALE [3] = '{WORD_BILLION, WORD_MILLION, WORD_THOUSAND};

  // one expected word token
  typedef struct packed {
    logic [4:0] code;
    logic       is_last;
  } word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;    // [30:0] number
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;         // [4:0] word_code
  logic        m_axis_tlast_o;         // last_word

  word_t       pending_words [$];
  int unsigned numbers_sent = 0;
  int unsigned words_checked = 0;
  int unsigned mismatches = 0;
  bit          no_gaps = 1'b0;

  integer_to_english_word_tokens dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // random idle decision, true with a chance of about 11 in a hundred
  function automatic bit take_gap();
    return !no_gaps && ($urandom_range(99) < 11);
  endfunction

  // expected word tokens for one number, appended to the pending store
  function automatic void spell_number(input logic [31:0] raw);
    int unsigned num;
    int unsigned grp;
    int unsigned hund;
    int unsigned tens;
    int unsigned ones;
    word_t       words [$];
    num = int'(raw[30:0]);
    if (num == 0) begin
      words.insert(words.size(), word_t'{WORD_ZERO, 1'b0});
    end else begin
      for (int k = 0; k < 4; k++) begin
        grp  = (num / GROUP_DIV[k]) % 1000;
        hund = grp / 100;
        tens = (grp / 10) % 10;
        ones = grp % 10;
        if (grp != 0) begin
          if (hund != 0) begin
            words.insert(words.size(), word_t'{5'(hund), 1'b0});
            words.insert(words.size(), word_t'{WORD_HUNDRED, 1'b0});
          end
          if (tens == 1) begin
            words.insert(words.size(), word_t'{WORD_TEN + 5'(ones), 1'b0});
          end else begin
            if (tens >= 2) begin
              words.insert(words.size(), word_t'{WORD_TWENTY + 5'(tens - 2), 1'b0});
            end
            if (ones != 0) words.insert(words.size(), word_t'{5'(ones), 1'b0});
          end
          if (k < 3) words.insert(words.size(), word_t'{GROUP_SCALE[k], 1'b0});
        end
      end
    end
    words[words.size() - 1].is_last = 1'b1;
    foreach (words[i]) pending_words.insert(pending_words.size(), words[i]);
  endfunction

  // random number: raw bits, a random digit count, or groups built from
  // zero, teen, round-hundred and arbitrary three-digit patterns
  function automatic logic [31:0] random_number();
    longint unsigned value;
    longint unsigned lo;
    longint unsigned hi;
    int unsigned     digits;
    logic [31:0]     raw;
    case ($urandom_range(2))
      0: value = $urandom;
      1: begin
        digits = $urandom_range(1, 10);
        lo = 1;
        repeat (digits - 1) lo = lo * 10;
        hi = lo * 10 - 1;
        if (digits == 1) lo = 0;
        if (hi > MAX_NUMBER) hi = MAX_NUMBER;
        value = $urandom_range(int'(hi), int'(lo));
      end
      default: begin
        value = $urandom_range(2);
        for (int k = 1; k < 4; k++) begin
          case ($urandom_range(3))
            0: value = value * 1000;
            1: value = value * 1000 + 100 * $urandom_range(9) + $urandom_range(19, 10);
            2: value = value * 1000 + 100 * $urandom_range(9, 1);
            default: value = value * 1000 + $urandom_range(999);
          endcase
        end
        if (value > MAX_NUMBER) value = value - 1000000000;
      end
    endcase
    raw = 32'(value);
    raw[31] = 1'($urandom_range(1));
    return raw;
  endfunction

  // send one number over the input channel, with random idle cycles first
  task automatic send_number(input logic [31:0] raw);
    while (take_gap()) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= $urandom;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= raw;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    spell_number(raw);
    numbers_sent++;
  endtask

  // zero, units, teens, tens and hundreds within a single group
  task automatic test_single_group();
    send_number(32'd0);
    send_number(32'd1);
    send_number(32'd7);
    send_number(32'd10);
    send_number(32'd13);
    send_number(32'd19);
    send_number(32'd20);
    send_number(32'd45);
    send_number(32'd99);
    send_number(32'd100);
    send_number(32'd118);
    send_number(32'd860);
    send_number(32'd999);
  endtask

  // scale words and zero groups between non-zero ones
  task automatic test_scales();
    send_number(32'd1000);
    send_number(32'd1000000);
    send_number(32'd1000001);
    send_number(32'd1000000000);
    send_number(32'd2000001000);
    send_number(32'd1234567890);
  endtask

  // longest word runs and the ignored top bit
  task automatic test_extremes();
    send_number(32'd1777777777);
    send_number(32'd2147483647);
    send_number(32'h8000_0000);
    send_number(32'hFFFF_FFFF);
  endtask

  // random numbers with idle cycles on both channels
  task automatic test_random_numbers(input int unsigned count);
    repeat (count) send_number(random_number());
  endtask

  // random numbers back to back with the receiver always ready
  task automatic test_random_no_gaps(input int unsigned count);
    no_gaps = 1'b1;
    repeat (count) send_number(random_number());
    no_gaps = 1'b0;
  endtask

  // receiver ready with random stalls
  always @(posedge clk_i) begin
    m_axis_tready_i <= !take_gap();
  end

  // compare each output transaction with the oldest expected word
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected word: code %0d last %0b", m_axis_tdata_o[4:0], m_axis_tlast_o);
        end
      end else begin
        if (m_axis_tdata_o[4:0] !== pending_words[0].code ||
            m_axis_tlast_o !== pending_words[0].is_last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("word mismatch: expected code %0d last %0b, got code %0d last %0b",
                     pending_words[0].code, pending_words[0].is_last,
                     m_axis_tdata_o[4:0], m_axis_tlast_o);
          end
        end
        void'(pending_words.pop_front());
        words_checked++;
      end
    end
  end

  // watchdog on cycles without any transaction
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("timeout with %0d words outstanding", pending_words.size());
    $display("integer_to_english_word_tokens test failed");
    $finish;
  end

  // main sequence
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_single_group();
    test_scales();
    test_extremes();
    test_random_numbers(77);
    test_random_no_gaps(30);
    s_axis_tvalid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("spelled %0d numbers into %0d word tokens, directed and random,", numbers_sent,
             words_checked);
    $display("with random stalls on both channels and one stretch without any");
    if (mismatches == 0) begin
      $display("integer_to_english_word_tokens test passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("integer_to_english_word_tokens test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/itew_pkg.sv
rtl/itew_bcd.sv
rtl/itew_seq.sv
rtl/integer_to_english_word_tokens.sv
verif/tb_integer_to_english_word_tokens.sv
